@@ rtl/core/tce_pkg.sv @@
package tce_pkg;

    localparam int unsigned DEF_COLUMNS = 80;
    localparam int unsigned DEF_ROWS    = 25;

    localparam logic [7:0] DEF_COLOR_RST = 8'h07;
    localparam logic [7:0] ERR_COLOR_RST = 8'h04;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_U  = 8'h75;

    localparam logic [2:0] REQ_FORMAT   = 3'd0;
    localparam logic [2:0] REQ_PLAIN    = 3'd1;
    localparam logic [2:0] REQ_ERASE    = 3'd2;
    localparam logic [2:0] REQ_BOUNDARY = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;

    localparam logic REG_DEFAULT = 1'b0;
    localparam logic REG_ERROR   = 1'b1;

    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned DEC_BITS   = 32;

    typedef enum logic [1:0] {
        PS_NORMAL,
        PS_PERCENT,
        PS_COLOR
    } t_parse;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_PUT,
        S_DIGIT,
        S_BCD,
        S_SKIP,
        S_NL,
        S_SCR_RD,
        S_SCR_CP,
        S_SCR_FILL,
        S_ERASE,
        S_ECHK,
        S_ETEST,
        S_RDWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  char_code;
        logic [31:0] arg_value;
        logic [7:0]  erase_count;
        logic [10:0] cell_index;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  col_pos;
        logic [4:0]  row_pos;
        logic [15:0] cell_value;
        logic [7:0]  color_now;
    } t_res;

endpackage

@@ rtl/core/tce_ram.sv @@
module tce_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tce_bcd.sv @@
module tce_bcd
    import tce_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DEC_BITS-1:0]       i_value,
    output logic                      o_done,
    output logic [4*DEC_DIGITS-1:0]   o_bcd
);

    localparam int unsigned CW = $clog2(DEC_BITS);

    logic [DEC_BITS-1:0]     r_bin, n_bin;
    logic [4*DEC_DIGITS-1:0] r_bcd, n_bcd;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [4*DEC_DIGITS-1:0] adj;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[4*DEC_DIGITS-2:0], r_bin[DEC_BITS-1]};
            n_bin = {r_bin[DEC_BITS-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DEC_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

@@ rtl/core/tce_seq.sv @@
module tce_seq
    import tce_pkg::*;
#(
    parameter int unsigned COLUMNS = DEF_COLUMNS,
    parameter int unsigned ROWS    = DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_def_color,
    input  logic [7:0] i_err_color,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_res       o_res
);

    localparam int unsigned CELLS = COLUMNS * ROWS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned COL_W = $clog2(COLUMNS);
    localparam int unsigned ROW_W = $clog2(ROWS + 1);

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    t_parse             r_parse, n_parse;
    t_cmd               r_cmd, n_cmd;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [7:0]         r_color, n_color;
    logic [7:0]         r_char, n_char;
    logic [AW-1:0]      r_addr, n_addr;
    logic [7:0]         r_cnt, n_cnt;
    logic [3:0]         r_pos, n_pos;
    logic               r_dig, n_dig;
    logic [15:0]        r_cell, n_cell;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [15:0]        wdata, rdata;
    logic               bcd_start, bcd_done;
    logic [4*DEC_DIGITS-1:0] bcd;
    logic [3:0]         digit;
    logic [COL_W-1:0]   bk_col;
    logic [ROW_W-1:0]   bk_row;

    function automatic logic [AW-1:0] cell_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        return AW'(row * COLUMNS + col);
    endfunction

    tce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tce_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_value (r_cmd.arg_value),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    assign digit = bcd[r_pos*4 +: 4];

    // cursor moved back one position
    always_comb begin
        bk_col = r_col;
        bk_row = r_row;
        if (r_col != '0) begin
            bk_col = r_col - COL_W'(1);
        end else if (r_row != '0) begin
            bk_row = r_row - ROW_W'(1);
            bk_col = COL_W'(COLUMNS - 1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_parse   = r_parse;
        n_cmd     = r_cmd;
        n_col     = r_col;
        n_row     = r_row;
        n_color   = r_color;
        n_char    = r_char;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_dig     = r_dig;
        n_cell    = r_cell;
        we        = 1'b0;
        waddr     = '0;
        wdata     = '0;
        raddr     = '0;
        bcd_start = 1'b0;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_addr;
                wdata = {DEF_COLOR_RST, CH_NUL};
                if (r_addr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cell  = '0;
                n_dig   = 1'b0;
                n_state = S_DONE;
                unique case (r_cmd.req_type)
                    REQ_FORMAT: begin
                        unique case (r_parse)
                            PS_PERCENT: begin
                                n_parse = PS_NORMAL;
                                if (r_cmd.char_code == CH_PCT) begin
                                    n_char  = CH_PCT;
                                    n_state = S_PUT;
                                end else if (r_cmd.char_code == CH_LC_C) begin
                                    n_parse = PS_COLOR;
                                end else if (r_cmd.char_code == CH_LC_U) begin
                                    bcd_start = 1'b1;
                                    n_state   = S_BCD;
                                end
                            end
                            PS_COLOR: begin
                                n_parse = PS_NORMAL;
                                if (r_cmd.char_code == CH_LC_D) begin
                                    n_color = i_def_color;
                                end else if (r_cmd.char_code == CH_LC_E) begin
                                    n_color = i_err_color;
                                end else if (r_cmd.char_code == CH_LC_C) begin
                                    n_color = r_cmd.arg_value[7:0];
                                end
                            end
                            default: begin
                                n_parse = PS_NORMAL;
                                if (r_cmd.char_code == CH_LF) begin
                                    n_state = S_NL;
                                end else if (r_cmd.char_code == CH_PCT) begin
                                    n_parse = PS_PERCENT;
                                end else begin
                                    n_char  = r_cmd.char_code;
                                    n_state = S_PUT;
                                end
                            end
                        endcase
                    end
                    REQ_PLAIN: begin
                        n_char  = r_cmd.char_code;
                        n_state = S_PUT;
                    end
                    REQ_ERASE: begin
                        n_cnt   = r_cmd.erase_count;
                        n_state = S_ERASE;
                    end
                    REQ_BOUNDARY: begin
                        n_color = i_def_color;
                        n_parse = PS_NORMAL;
                    end
                    REQ_READ: begin
                        if (32'(r_cmd.cell_index) < CELLS) begin
                            raddr   = AW'(r_cmd.cell_index);
                            n_state = S_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PUT: begin
                if (r_row >= ROW_W'(ROWS)) begin
                    n_ret   = S_PUT;
                    n_addr  = AW'(COLUMNS);
                    n_state = S_SCR_RD;
                end else begin
                    we    = 1'b1;
                    waddr = cell_addr(r_row, r_col);
                    wdata = {r_color, r_char};
                    if (r_col == COL_W'(COLUMNS - 1)) begin
                        n_col = '0;
                        n_row = r_row + ROW_W'(1);
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                    if (r_dig && r_pos != '0) begin
                        n_pos   = r_pos - 4'd1;
                        n_state = S_DIGIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIGIT: begin
                n_char  = CH_ZERO | {4'd0, digit};
                n_state = S_PUT;
            end
            S_BCD: begin
                if (bcd_done) begin
                    n_pos   = 4'(DEC_DIGITS - 1);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (digit == 4'd0 && r_pos != '0) begin
                    n_pos = r_pos - 4'd1;
                end else begin
                    n_dig   = 1'b1;
                    n_state = S_DIGIT;
                end
            end
            S_NL: begin
                n_addr = AW'(COLUMNS);
                if (r_row >= ROW_W'(ROWS)) begin
                    n_ret   = S_NL;
                    n_state = S_SCR_RD;
                end else begin
                    n_row = r_row + ROW_W'(1);
                    n_col = '0;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        n_ret   = S_DONE;
                        n_state = S_SCR_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCR_RD: begin
                raddr   = r_addr;
                n_state = S_SCR_CP;
            end
            S_SCR_CP: begin
                we    = 1'b1;
                waddr = r_addr - AW'(COLUMNS);
                wdata = rdata;
                if (r_addr == AW'(CELLS - 1)) begin
                    n_addr  = AW'((ROWS - 1) * COLUMNS);
                    n_state = S_SCR_FILL;
                end else begin
                    raddr  = r_addr + AW'(1);
                    n_addr = r_addr + AW'(1);
                end
            end
            S_SCR_FILL: begin
                we    = 1'b1;
                waddr = r_addr;
                wdata = {r_color, CH_SPACE};
                if (r_addr == AW'(CELLS - 1)) begin
                    if (r_row != '0) begin
                        n_row = r_row - ROW_W'(1);
                    end
                    n_state = r_ret;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_ERASE: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_cnt - 8'd1;
                    n_col   = bk_col;
                    n_row   = bk_row;
                    we      = 1'b1;
                    waddr   = cell_addr(bk_row, bk_col);
                    wdata   = {r_color, CH_NUL};
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                if (r_col == '0) begin
                    n_state = S_ERASE;
                end else begin
                    raddr   = cell_addr(r_row, r_col - COL_W'(1));
                    n_state = S_ETEST;
                end
            end
            S_ETEST: begin
                if (rdata[7:0] != CH_NUL) begin
                    n_state = S_ERASE;
                end else begin
                    n_col   = r_col - COL_W'(1);
                    n_state = S_ECHK;
                end
            end
            S_RDWAIT: begin
                n_cell  = rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_DONE;
            r_parse <= PS_NORMAL;
            r_col   <= '0;
            r_row   <= '0;
            r_color <= DEF_COLOR_RST;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_dig   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_parse <= n_parse;
            r_col   <= n_col;
            r_row   <= n_row;
            r_color <= n_color;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_dig   <= n_dig;
        end
        r_cmd  <= n_cmd;
        r_char <= n_char;
        r_cell <= n_cell;
    end

    assign o_res.col_pos    = 7'(r_col);
    assign o_res.row_pos    = 5'(r_row);
    assign o_res.cell_value = r_cell;
    assign o_res.color_now  = r_color;

endmodule

@@ rtl/core/text_console_engine.sv @@
// plain write: decode, put and done states; a scroll moves rows up and blanks the last row
// decimal print: shift-and-add-3 conversion, leading zeros skipped, then each digit put
// erase: steps back over NUL cells in the row; one request at a time
// reset: synchronous, active low; cursor, color and parser cleared
// after reset the screen memory is swept to NUL on color 0x07 before requests are taken
module text_console_engine
    import tce_pkg::*;
#(
    parameter int unsigned COLUMNS = DEF_COLUMNS,
    parameter int unsigned ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_arg_value,
    input  logic [7:0]  i_erase_count,
    input  logic [10:0] i_cell_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_col_pos,
    output logic [4:0]  o_row_pos,
    output logic [15:0] o_cell_value,
    output logic [7:0]  o_color_now,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_def_color;
    logic [7:0] r_err_color;
    logic       r_valid, n_valid;
    t_res       r_res;
    t_cmd       cmd;
    t_res       res;
    logic       res_valid, res_ready;

    assign cmd = '{req_type: i_req_type, char_code: i_char_code, arg_value: i_arg_value,
                   erase_count: i_erase_count, cell_index: i_cell_index};

    tce_seq #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_valid),
        .o_cmd_ready (o_ready),
        .i_cmd       (cmd),
        .i_def_color (r_def_color),
        .i_err_color (r_err_color),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (res_valid && res_ready) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_def_color <= DEF_COLOR_RST;
            r_err_color <= ERR_COLOR_RST;
        end else begin
            r_valid <= n_valid;
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_ERROR) begin
                    r_err_color <= pwdata[7:0];
                end else begin
                    r_def_color <= pwdata[7:0];
                end
            end
        end
        if (res_valid && res_ready) begin
            r_res <= res;
        end
    end

    assign pready       = 1'b1;
    assign prdata       = {24'd0, (paddr[2] == REG_ERROR) ? r_err_color : r_def_color};
    assign o_valid      = r_valid;
    assign o_col_pos    = r_res.col_pos;
    assign o_row_pos    = r_res.row_pos;
    assign o_cell_value = r_res.cell_value;
    assign o_color_now  = r_res.color_now;

`ifndef SYNTHESIS
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while sequencer stays idle");
    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_col_pos) < COLUMNS))
        else $error("cursor column out of range");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("result or ready after reset");
`endif

endmodule
